// ===== rtl/core/ngls_pkg.sv =====
package ngls_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_NOTE_ON = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RESET   = 2'd2;

    // Gate modes
    localparam logic [1:0] MODE_PERCENT = 2'd0;
    localparam logic [1:0] MODE_MS      = 2'd1;
    localparam logic [1:0] MODE_TICKS   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE     = 3'd0;
    localparam logic [2:0] CFG_MODE       = 3'd1;
    localparam logic [2:0] CFG_GATE_VALUE = 3'd2;
    localparam logic [2:0] CFG_MIN_LENGTH = 3'd3;
    localparam logic [2:0] CFG_MAX_LENGTH = 3'd4;
    localparam logic [2:0] CFG_TRACK_ID   = 3'd5;

    localparam logic [15:0] GATE_VALUE_RST = 16'd100;

    // Gate length arithmetic: 500 ms base, percent, 96 ticks per base
    localparam int unsigned BASE_MS        = 500;
    localparam int unsigned PCT_DIV        = 100;
    localparam int unsigned PCT_MULT       = BASE_MS / PCT_DIV;
    localparam int unsigned TICKS_PER_BASE = 96;
    // 96 = 32 * 3: shift by 5, then divide by 3 through a reciprocal
    localparam int unsigned TICK_SHIFT     = 5;
    localparam int unsigned RECIP3_SHIFT   = 21;
    localparam int unsigned RECIP3         = ((1 << RECIP3_SHIFT) + 2) / 3;
    localparam int unsigned LEN_W          = 20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_A,
        S_LEN_B,
        S_LEN_C,
        S_LEN_SET,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [31:0] time_ms;
    } t_in;

    typedef struct packed {
        logic        msg_valid;
        logic        accepted;
        logic [3:0]  out_track;
        logic [6:0]  out_note;
        logic [6:0]  out_velocity;
        logic [3:0]  out_channel;
        logic [4:0]  active_count;
        logic [31:0] total_count;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [6:0]  note;
        logic [3:0]  channel;
        logic [31:0] off_time;
    } t_slot;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] gate_value;
        logic [15:0] min_length;
        logic [15:0] max_length;
    } t_gate_cfg;

endpackage

// ===== rtl/core/note_gate_length_scheduler.sv =====
// Gate-time scheduler for one MIDI track, one item at a time under a small sequencer.
// Note-on: accept, then the 3-stage length unit, the store into the slot RAM and the flush;
// a rejected note-on or unused function goes straight to flush; the input stalls until flush ends.
// Tick / release-all: slots are scanned one at a time through the single slot-RAM read port
// and shared compare; a held slot's check waits while a note-off cannot reach the output.
// Reset (sync, active low) clears slot valid bits, counts, config; slot RAM is not cleared.
module note_gate_length_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ngls_pkg::t_in      i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ngls_pkg::t_out     o_out_data,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // ---------------------------------------------------------------- config
    logic        r_enable;
    logic [1:0]  r_mode;
    logic [15:0] r_gate_value;
    logic [15:0] r_min_length;
    logic [15:0] r_max_length;
    logic [3:0]  r_track_id;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_mode       <= ngls_pkg::MODE_PERCENT;
            r_gate_value <= ngls_pkg::GATE_VALUE_RST;
            r_min_length <= '0;
            r_max_length <= '0;
            r_track_id   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ngls_pkg::CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                ngls_pkg::CFG_MODE:       r_mode       <= i_cfg_data[1:0];
                ngls_pkg::CFG_GATE_VALUE: r_gate_value <= i_cfg_data;
                ngls_pkg::CFG_MIN_LENGTH: r_min_length <= i_cfg_data;
                ngls_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                ngls_pkg::CFG_TRACK_ID:   r_track_id   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------ gate length unit
    // Free-running from the config registers; three stages settle well before
    // the store step reads the length.
    ngls_pkg::t_gate_cfg        w_gate_cfg;
    logic [ngls_pkg::LEN_W-1:0] w_len;

    assign w_gate_cfg = '{mode:       r_mode,
                          gate_value: r_gate_value,
                          min_length: r_min_length,
                          max_length: r_max_length};

    ngls_len u_len (
        .i_clk (i_clk),
        .i_cfg (w_gate_cfg),
        .o_len (w_len)
    );

    // ---------------------------------------------------------------- state
    ngls_pkg::t_state r_state, n_state;
    logic [SLOTS-1:0] r_active, n_active;
    logic [CW-1:0]    r_held, n_held;
    logic [31:0]      r_total, n_total;
    ngls_pkg::t_in    r_item, n_item;
    logic [IW-1:0]    r_slot, n_slot;
    logic [IW-1:0]    r_idx, n_idx;
    ngls_pkg::t_out   r_pend, n_pend;
    logic             r_pend_v, n_pend_v;
    ngls_pkg::t_out   r_out, n_out;
    logic             r_out_v, n_out_v;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_idx_last;
    logic             w_free_found;
    logic [IW-1:0]    w_free_idx;
    logic             w_hit;
    logic             w_chk_wait;
    logic             w_ram_we;
    ngls_pkg::t_slot  w_wr_slot;
    ngls_pkg::t_slot  w_rd_slot;
    ngls_pkg::t_out   w_empty;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_idx_last = (r_idx == IW'(SLOTS - 1));

    // lowest free slot
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    // shared compare: expiry or release-all
    assign w_hit = (r_item.func == ngls_pkg::FUNC_RESET) ||
                   (r_enable && (r_item.time_ms >= w_rd_slot.off_time));
    // a previous note-off still waits for the output register
    assign w_chk_wait = w_hit && r_pend_v && !w_out_free;

    // ------------------------------------------------------------ slot store
    assign w_wr_slot = '{note:     r_item.note,
                         channel:  r_item.channel,
                         off_time: r_item.time_ms + 32'(w_len)};

    ngls_ram #(
        .WIDTH ($bits(ngls_pkg::t_slot)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (w_wr_slot),
        .i_raddr (r_idx),
        .o_rdata (w_rd_slot)
    );

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ngls_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    priority if (i_in_data.func == ngls_pkg::FUNC_NOTE_ON) begin
                        n_state = (r_enable && w_free_found) ? ngls_pkg::S_LEN_A
                                                             : ngls_pkg::S_FLUSH;
                    end else if (i_in_data.func == ngls_pkg::FUNC_TICK ||
                                 i_in_data.func == ngls_pkg::FUNC_RESET) begin
                        n_state = ngls_pkg::S_SCAN_RD;
                    end else begin
                        n_state = ngls_pkg::S_FLUSH;
                    end
                end
            end
            ngls_pkg::S_LEN_A:   n_state = ngls_pkg::S_LEN_B;
            ngls_pkg::S_LEN_B:   n_state = ngls_pkg::S_LEN_C;
            ngls_pkg::S_LEN_C:   n_state = ngls_pkg::S_LEN_SET;
            ngls_pkg::S_LEN_SET: n_state = ngls_pkg::S_FLUSH;
            ngls_pkg::S_SCAN_RD: begin
                if (r_active[r_idx]) begin
                    n_state = ngls_pkg::S_SCAN_CHK;
                end else if (w_idx_last) begin
                    n_state = ngls_pkg::S_FLUSH;
                end
            end
            ngls_pkg::S_SCAN_CHK: begin
                if (!w_chk_wait) begin
                    n_state = w_idx_last ? ngls_pkg::S_FLUSH : ngls_pkg::S_SCAN_RD;
                end
            end
            ngls_pkg::S_FLUSH: begin
                if (w_out_free) begin
                    n_state = ngls_pkg::S_IDLE;
                end
            end
            default: n_state = ngls_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------- control outs
    always_comb begin
        o_in_stall = (r_state != ngls_pkg::S_IDLE);
        w_ram_we   = (r_state == ngls_pkg::S_LEN_SET);
    end

    // -------------------------------------------------------------- datapath
    // Each result word is parked in r_pend until it is known whether another
    // follows, so the last flag is always right.
    always_comb begin
        w_empty              = '0;
        w_empty.active_count = 5'(r_held);
        w_empty.total_count  = r_total;

        n_active = r_active;
        n_held   = r_held;
        n_total  = r_total;
        n_item   = r_item;
        n_slot   = r_slot;
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_out_v  = r_out_v && i_out_stall;

        unique case (r_state)
            ngls_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_item   = i_in_data;
                    n_slot   = w_free_idx;
                    n_idx    = '0;
                    n_pend_v = 1'b0;
                end
            end
            ngls_pkg::S_LEN_SET: begin
                n_active[r_slot]    = 1'b1;
                n_held              = r_held + CW'(1);
                n_total             = r_total + 32'd1;
                n_pend.msg_valid    = 1'b1;
                n_pend.accepted     = 1'b1;
                n_pend.out_track    = r_track_id;
                n_pend.out_note     = r_item.note;
                n_pend.out_velocity = r_item.velocity;
                n_pend.out_channel  = r_item.channel;
                n_pend.active_count = 5'(r_held + CW'(1));
                n_pend.total_count  = r_total + 32'd1;
                n_pend.last         = 1'b0;
                n_pend_v            = 1'b1;
            end
            ngls_pkg::S_SCAN_RD: begin
                if (!r_active[r_idx] && !w_idx_last) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ngls_pkg::S_SCAN_CHK: begin
                if (!w_chk_wait) begin
                    if (w_hit) begin
                        if (r_pend_v) begin
                            n_out   = r_pend;
                            n_out_v = 1'b1;
                        end
                        n_active[r_idx]     = 1'b0;
                        n_held              = r_held - CW'(1);
                        n_pend.msg_valid    = 1'b1;
                        n_pend.accepted     = 1'b0;
                        n_pend.out_track    = r_track_id;
                        n_pend.out_note     = w_rd_slot.note;
                        n_pend.out_velocity = '0;
                        n_pend.out_channel  = w_rd_slot.channel;
                        n_pend.active_count = 5'(r_held - CW'(1));
                        n_pend.total_count  = r_total;
                        n_pend.last         = 1'b0;
                        n_pend_v            = 1'b1;
                    end
                    if (!w_idx_last) begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ngls_pkg::S_FLUSH: begin
                if (w_out_free) begin
                    n_out      = r_pend_v ? r_pend : w_empty;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ngls_pkg::S_IDLE;
            r_active <= '0;
            r_held   <= '0;
            r_total  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_held   <= n_held;
            r_total  <= n_total;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_slot <= n_slot;
        r_idx  <= n_idx;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------ assertions
    a_held_matches_slots : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_active) == int'(r_held))
        else $error("held count out of step with slot valid bits");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while previous still in progress");

    a_note_off_velocity : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.msg_valid && !o_out_data.accepted)
        |-> (o_out_data.out_velocity == 7'd0))
        else $error("note-off word with nonzero velocity");

    a_flush_ends_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ngls_pkg::S_FLUSH && w_out_free)
        |=> (o_out_valid && o_out_data.last && !r_pend_v))
        else $error("final word of an item not delivered with last set");

endmodule

// ===== rtl/core/ngls_ram.sv =====
module ngls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/ngls_len.sv =====
module ngls_len (
    input  logic                            i_clk,
    input  ngls_pkg::t_gate_cfg             i_cfg,
    output logic [ngls_pkg::LEN_W-1:0]      o_len
);

    logic [1:0]                  r_mode_a;
    logic [ngls_pkg::LEN_W-1:0]  r_base_a;
    logic [ngls_pkg::LEN_W-1:0]  r_len_b;
    logic [ngls_pkg::LEN_W-1:0]  r_len_c;
    logic [ngls_pkg::LEN_W-1:0]  n_base_a;
    logic [ngls_pkg::LEN_W-1:0]  n_len_b;
    logic [ngls_pkg::LEN_W-1:0]  n_len_c;
    logic [39:0]                 w_prod;

    // stage A: scale gate value by mode
    always_comb begin
        unique case (i_cfg.mode)
            ngls_pkg::MODE_PERCENT: begin
                n_base_a = ngls_pkg::LEN_W'(32'(i_cfg.gate_value) * ngls_pkg::PCT_MULT);
            end
            ngls_pkg::MODE_MS: begin
                n_base_a = ngls_pkg::LEN_W'(i_cfg.gate_value);
            end
            ngls_pkg::MODE_TICKS: begin
                n_base_a = ngls_pkg::LEN_W'((32'(i_cfg.gate_value) * ngls_pkg::BASE_MS)
                                            >> ngls_pkg::TICK_SHIFT);
            end
            default: begin
                n_base_a = ngls_pkg::LEN_W'(ngls_pkg::BASE_MS);
            end
        endcase
    end

    // stage B: divide by 3 (ticks mode), exact below 2^20
    assign w_prod = 40'(r_base_a) * 40'(ngls_pkg::RECIP3);

    always_comb begin
        if (r_mode_a == ngls_pkg::MODE_TICKS) begin
            n_len_b = ngls_pkg::LEN_W'(w_prod >> ngls_pkg::RECIP3_SHIFT);
        end else begin
            n_len_b = r_base_a;
        end
    end

    // stage C: limits, floor of 1 ms
    always_comb begin
        n_len_c = r_len_b;
        if (i_cfg.min_length != 16'd0 && n_len_c < ngls_pkg::LEN_W'(i_cfg.min_length)) begin
            n_len_c = ngls_pkg::LEN_W'(i_cfg.min_length);
        end
        if (i_cfg.max_length != 16'd0 && n_len_c > ngls_pkg::LEN_W'(i_cfg.max_length)) begin
            n_len_c = ngls_pkg::LEN_W'(i_cfg.max_length);
        end
        if (n_len_c == '0) begin
            n_len_c = ngls_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode_a <= i_cfg.mode;
        r_base_a <= n_base_a;
        r_len_b  <= n_len_b;
        r_len_c  <= n_len_c;
    end

    assign o_len = r_len_c;

endmodule
